// ===== src/sst_pkg.sv =====
// ---------------------------------------------------------------------------
// sst_pkg: shared types and codes for the sorted set table
// Operation and status codes, and the control and status bundles that pass
// between the top level and the storage cells.
// ---------------------------------------------------------------------------
package sst_pkg;

  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  // Broadcast to every cell in the accept cycle
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      clr;
    logic signed [VALUE_W-1:0] key;
  } cell_ctrl_t;

  // Per-cell compare results
  typedef struct packed {
    logic lt;   // valid and entry below key
    logic eq;   // valid and entry equal to key
    logic bnd;  // first cell not below key: insert point
  } cell_stat_t;

endpackage

// ===== src/sst_cell.sv =====
// ---------------------------------------------------------------------------
// sst_cell: one slot of the sorted chain
// Holds one value and its valid bit, compares against the broadcast key and
// shifts toward either neighbor on insert or delete.
// ---------------------------------------------------------------------------
module sst_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  sst_pkg::cell_ctrl_t                ctrl,
  input  logic                               left_lt,
  input  logic                               left_valid,
  input  logic signed [sst_pkg::VALUE_W-1:0] left_entry,
  input  logic                               right_valid,
  input  logic signed [sst_pkg::VALUE_W-1:0] right_entry,
  output logic                               valid,
  output logic signed [sst_pkg::VALUE_W-1:0] entry,
  output sst_pkg::cell_stat_t                stat
);
  import sst_pkg::*;

  // Compare held value against the key
  always_comb begin
    stat.lt  = valid && (entry < ctrl.key);
    stat.eq  = valid && (entry == ctrl.key);
    stat.bnd = !stat.lt && left_lt;
  end

  // Valid bit: grow from the left on insert, shrink from the right on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clr) begin
      valid <= 1'b0;
    end else if (ctrl.ins && !stat.lt) begin
      valid <= valid | left_valid;
    end else if (ctrl.del && !stat.lt) begin
      valid <= right_valid;
    end
  end

  // Payload: take key at the insert point, else shift from a neighbor
  always_ff @(posedge clk) begin
    if (ctrl.ins && !stat.lt) begin
      entry <= stat.bnd ? ctrl.key : left_entry;
    end else if (ctrl.del && !stat.lt) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== src/sorted_set_table_top.sv =====
// ---------------------------------------------------------------------------
// sorted_set_table_top: bounded sorted set of signed 32-bit values
// Insert, delete, find and clear on a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells, kept in ascending signed order
// from cell 0. Every cell compares its value with the request in the same
// cycle and shifts one place left or right, so each request is finished in
// the cycle it is accepted and one request is taken per clock unless the
// output stalls. The result beat sits in an output register; a new request
// is taken whenever that register is empty or is being drained in the same
// cycle, so throughput is one beat per cycle with out_ready held high.
// Position and count are reported modulo 16 and 32.
module sorted_set_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sst_pkg::MODE_W-1:0]          mode,
  input  logic signed [sst_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sst_pkg::STATUS_W-1:0]        status,
  output logic [sst_pkg::POS_W-1:0]           position,
  output logic [sst_pkg::COUNT_W-1:0]         count
);
  import sst_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic                       accept;
  logic                       hit;
  logic                       full;
  logic [OCC_W-1:0]           occupancy;
  logic [OCC_W-1:0]           occupancy_next;
  logic [STATUS_W-1:0]        status_next;
  logic [POS_W-1:0]           pos_next;
  logic [POS_W-1:0]           pos_enc;
  logic [CAPACITY-1:0]        valid_vec;
  logic [CAPACITY-1:0]        lt_vec;
  logic [CAPACITY-1:0]        eq_vec;
  logic [CAPACITY-1:0]        bnd_vec;
  logic [CAPACITY-1:0]        sel_vec;
  logic signed [VALUE_W-1:0]  entry_arr [CAPACITY];
  cell_stat_t                 stat_arr  [CAPACITY];
  cell_ctrl_t                 ctrl;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign hit      = |eq_vec;
  assign full     = valid_vec[CAPACITY-1];

  // Broadcast the decoded operation to the chain
  always_comb begin
    ctrl.key = value;
    ctrl.ins = accept && (mode == MODE_INSERT) && !hit && !full;
    ctrl.del = accept && (mode == MODE_DELETE) && hit;
    ctrl.clr = accept && (mode == MODE_CLEAR);
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_lt;
    logic                      l_valid;
    logic                      r_valid;
    logic signed [VALUE_W-1:0] l_entry;
    logic signed [VALUE_W-1:0] r_entry;

    if (i == 0) begin : g_head
      assign l_lt    = 1'b1;
      assign l_valid = 1'b1;
      assign l_entry = value;
    end else begin : g_mid
      assign l_lt    = lt_vec[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_entry = entry_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = entry_arr[i];
    end else begin : g_body
      assign r_valid = valid_vec[i+1];
      assign r_entry = entry_arr[i+1];
    end

    sst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_lt     (l_lt),
      .left_valid  (l_valid),
      .left_entry  (l_entry),
      .right_valid (r_valid),
      .right_entry (r_entry),
      .valid       (valid_vec[i]),
      .entry       (entry_arr[i]),
      .stat        (stat_arr[i])
    );

    assign lt_vec[i]  = stat_arr[i].lt;
    assign eq_vec[i]  = stat_arr[i].eq;
    assign bnd_vec[i] = stat_arr[i].bnd;
  end

  // Encode the one-hot hit or insert point into a position
  assign sel_vec = (mode == MODE_INSERT) ? bnd_vec : eq_vec;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_enc = pos_enc | (sel_vec[i] ? POS_W'(i) : '0);
    end
  end

  // Result status, position and new occupancy
  always_comb begin
    status_next    = ST_DONE;
    pos_next       = '0;
    occupancy_next = occupancy;
    case (mode)
      MODE_INSERT: begin
        if (hit) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          pos_next       = pos_enc;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end
      MODE_DELETE: begin
        if (!hit) begin
          status_next = ST_ABSENT;
        end else begin
          pos_next       = pos_enc;
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
      MODE_FIND: begin
        if (!hit) begin
          status_next = ST_ABSENT;
        end else begin
          pos_next = pos_enc;
        end
      end
      default: begin
        occupancy_next = '0;
      end
    endcase
  end

  // Occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      position <= pos_next;
      count    <= COUNT_W'(occupancy_next);
    end
  end

  // Valid cells form a contiguous run from cell 0
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    else $error("valid cells are not contiguous from the head");

  // Occupancy tracks the number of valid cells
  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occupancy))
    else $error("occupancy disagrees with valid cells");

  // At most one cell matches the key
  a_eq_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq_vec))
    else $error("duplicate value held in the set");

  // At most one insert point
  a_bnd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bnd_vec))
    else $error("more than one insert point");

  // Clear empties the chain
  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clr |=> (valid_vec == '0) && (occupancy == '0))
    else $error("clear left entries in the set");

endmodule
